[rtl/core/gbc_pkg.sv]
// ----------------------------------------------------------------------------
// Gyro bias calibration package
// Shared widths, status codes, unit opcodes and the interface structs of the
// shared arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gbc_pkg;

    // Sample and counter widths
    localparam int AXES           = 3;
    localparam int ACCEL_W        = 16;
    localparam int GYRO_W         = 16;
    localparam int LIMIT_W        = 16;
    localparam int MAX_SAMPLES    = 1024;
    localparam int BIAS_FRAC_BITS = 8;
    localparam int CNT_W          = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W          = GYRO_W + CNT_W - 1;
    localparam int BIAS_W         = GYRO_W + BIAS_FRAC_BITS + 1;
    localparam int DVD_W          = SUM_W + BIAS_FRAC_BITS;
    localparam int STEP_W         = $clog2(DVD_W);
    localparam int SQ_W           = 2 * GYRO_W + 2;
    localparam int ACC_W          = 2 * LIMIT_W;
    localparam int STATUS_W       = 2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_MEAS   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FEW    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_MOTION = 2'd3;

    // Shared unit opcodes
    typedef enum logic [1:0] {
        ALU_MAC,
        ALU_CMP,
        ALU_DIV
    } alu_op_t;

    typedef struct packed {
        alu_op_t                    op;
        logic signed [GYRO_W-1:0]   gyro;
        logic [LIMIT_W-1:0]         limit;
        logic [ACC_W-1:0]           acc;
        logic [CNT_W-1:0]           rem;
        logic [DVD_W-1:0]           dvd;
        logic [CNT_W-1:0]           divisor;
    } alu_in_t;

    typedef struct packed {
        logic [ACC_W-1:0]           acc;
        logic                       gt;
        logic [CNT_W-1:0]           rem;
        logic [DVD_W-1:0]           dvd;
    } alu_out_t;

endpackage

`default_nettype wire

[rtl/core/gbc_alu.sv]
// ----------------------------------------------------------------------------
// Gyro bias calibration shared unit
// One squarer with accumulate/compare, and one restoring divide step.
// ----------------------------------------------------------------------------
`default_nettype none

module gbc_alu (
    input  wire gbc_pkg::alu_in_t  alu_in,
    output gbc_pkg::alu_out_t      alu_out
);

    logic signed [gbc_pkg::GYRO_W:0]    sq_op;
    logic signed [gbc_pkg::SQ_W-1:0]    sq_full;
    logic [gbc_pkg::ACC_W-1:0]          sq;
    logic [gbc_pkg::CNT_W:0]            rem_sh;
    logic                               ge;
    logic [gbc_pkg::CNT_W:0]            rem_sub;

    // Pick the squarer operand: a gyro axis or the motion limit
    always_comb
    begin
        unique case (alu_in.op)
            gbc_pkg::ALU_MAC: sq_op = {alu_in.gyro[gbc_pkg::GYRO_W-1], alu_in.gyro};
            gbc_pkg::ALU_CMP: sq_op = {1'b0, alu_in.limit};
            default:          sq_op = '0;
        endcase
    end

    // Square; the result is never negative and fits the accumulator
    assign sq_full = sq_op * sq_op;
    assign sq      = sq_full[gbc_pkg::ACC_W-1:0];

    assign alu_out.acc = alu_in.acc + sq;
    assign alu_out.gt  = alu_in.acc > sq;

    // Restoring divide: shift in one dividend bit, subtract if it fits
    assign rem_sh  = {alu_in.rem, alu_in.dvd[gbc_pkg::DVD_W-1]};
    assign ge      = rem_sh >= {1'b0, alu_in.divisor};
    assign rem_sub = rem_sh - {1'b0, alu_in.divisor};

    assign alu_out.rem = ge ? rem_sub[gbc_pkg::CNT_W-1:0] : rem_sh[gbc_pkg::CNT_W-1:0];
    assign alu_out.dvd = {alu_in.dvd[gbc_pkg::DVD_W-2:0], ge};

endmodule

`default_nettype wire

[rtl/core/gyro_bias_calibrate_correct_unit.sv]
// ----------------------------------------------------------------------------
// Gyro bias calibration and correction unit
// Measure items: the MEAS state registers the result once the output is free.
// Calibration items: a bad read passes the limit compare only, a good read
// first takes the three squaring passes, all through the shared unit.
// Run end: the run is judged; an accepted run then takes 34 divide steps per
// axis. A stalled result holds the unit; samples are taken only when idle.
// Reset clears bias, run state, handshakes; motion_limit resets to 640.
// ----------------------------------------------------------------------------
`default_nettype none

module gyro_bias_calibrate_correct_unit (
    input  wire          clk,
    input  wire          rst_n,

    // Configuration: motion_limit
    input  wire          cfg_valid,
    output logic         cfg_ready,
    input  wire [15:0]   cfg_data,

    // Sample stream
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire [95:0]   s_tdata,   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
    input  wire [1:0]    s_tuser,   // command, read_ok
    input  wire          s_tlast,   // last_of_run

    // Result stream
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [127:0] m_tdata,   // accel_x_out, accel_y_out, accel_z_out,
                                    // rate_x_out, rate_y_out, rate_z_out, zero pad
    output logic [1:0]   m_tuser    // status
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MEAS = 3'd1;
    localparam logic [2:0] S_SQ   = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_DEC  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    localparam int GW  = gbc_pkg::GYRO_W;
    localparam int AW  = gbc_pkg::ACCEL_W;
    localparam int BW  = gbc_pkg::BIAS_W;
    localparam int SW  = gbc_pkg::SUM_W;
    localparam int CW  = gbc_pkg::CNT_W;
    localparam int DW  = gbc_pkg::DVD_W;
    localparam int OUT_USED = 3 * AW + 3 * BW;

    localparam logic [CW-1:0] MAX_CNT = CW'(gbc_pkg::MAX_SAMPLES);
    localparam logic [gbc_pkg::STEP_W-1:0] LAST_STEP = gbc_pkg::STEP_W'(DW - 1);

    logic [2:0]                     state_reg, state_next;
    logic [gbc_pkg::LIMIT_W-1:0]    limit_reg, limit_next;

    logic                           read_ok_reg, read_ok_next;
    logic                           last_reg, last_next;
    logic signed [AW-1:0]           accel_reg [gbc_pkg::AXES];
    logic signed [AW-1:0]           accel_next [gbc_pkg::AXES];
    logic signed [GW-1:0]           gyro_reg [gbc_pkg::AXES];
    logic signed [GW-1:0]           gyro_next [gbc_pkg::AXES];

    logic signed [BW-1:0]           bias_reg [gbc_pkg::AXES];
    logic signed [BW-1:0]           bias_next [gbc_pkg::AXES];
    logic signed [SW-1:0]           sums_reg [gbc_pkg::AXES];
    logic signed [SW-1:0]           sums_next [gbc_pkg::AXES];
    logic [CW-1:0]                  attempt_reg, attempt_next;
    logic [CW-1:0]                  good_reg, good_next;
    logic                           motion_reg, motion_next;

    logic [1:0]                     axis_reg, axis_next;
    logic [gbc_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [gbc_pkg::ACC_W-1:0]      acc_reg, acc_next;
    logic [CW-1:0]                  rem_reg, rem_next;
    logic [DW-1:0]                  dvd_reg, dvd_next;
    logic                           neg_reg, neg_next;
    logic [gbc_pkg::STATUS_W-1:0]   status_reg, status_next;

    logic                           m_tvalid_reg, m_tvalid_next;
    logic [127:0]                   m_tdata_reg, m_tdata_next;
    logic [1:0]                     m_tuser_reg, m_tuser_next;

    gbc_pkg::alu_in_t               alu_in;
    gbc_pkg::alu_out_t              alu_out;

    logic                           in_xfer;
    logic                           out_free;
    logic [1:0]                     init_axis;
    logic signed [SW-1:0]           init_sum;
    logic [SW-1:0]                  init_mag;
    logic [DW-1:0]                  quot_signed;
    logic signed [BW-1:0]           rate [gbc_pkg::AXES];
    logic                           run_few;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Shared unit hookup
    always_comb
    begin
        alu_in.op      = gbc_pkg::ALU_DIV;
        if (state_reg == S_SQ)
        begin
            alu_in.op  = gbc_pkg::ALU_MAC;
        end
        else if (state_reg == S_UPD)
        begin
            alu_in.op  = gbc_pkg::ALU_CMP;
        end
        alu_in.gyro    = gyro_reg[axis_reg];
        alu_in.limit   = limit_reg;
        alu_in.acc     = acc_reg;
        alu_in.rem     = rem_reg;
        alu_in.dvd     = dvd_reg;
        alu_in.divisor = good_reg;
    end

    gbc_alu u_alu (
        .alu_in  (alu_in),
        .alu_out (alu_out)
    );

    // Divider setup for the next axis: magnitude of the sum, scaled
    assign init_axis = (state_reg == S_DEC) ? 2'd0 : axis_reg + 2'd1;
    assign init_sum  = sums_reg[init_axis];
    assign init_mag  = init_sum[SW-1] ? (~init_sum + 1'b1) : init_sum;

    // Signed quotient of the finishing divide
    assign quot_signed = neg_reg ? (~alu_out.dvd + 1'b1) : alu_out.dvd;

    // Bias-corrected rates
    always_comb
    begin
        for (int i = 0; i < gbc_pkg::AXES; i++)
        begin
            rate[i] = {gyro_reg[i][GW-1], gyro_reg[i], {gbc_pkg::BIAS_FRAC_BITS{1'b0}}}
                      - bias_reg[i];
        end
    end

    assign run_few = (good_reg == '0) || (good_reg < (attempt_reg >> 1));

    // Sequencer and datapath next state
    always_comb
    begin
        state_next    = state_reg;
        limit_next    = limit_reg;
        read_ok_next  = read_ok_reg;
        last_next     = last_reg;
        accel_next    = accel_reg;
        gyro_next     = gyro_reg;
        bias_next     = bias_reg;
        sums_next     = sums_reg;
        attempt_next  = attempt_reg;
        good_next     = good_reg;
        motion_next   = motion_reg;
        axis_next     = axis_reg;
        step_next     = step_reg;
        acc_next      = acc_reg;
        rem_next      = rem_reg;
        dvd_next      = dvd_reg;
        neg_next      = neg_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        // Drop the result once the sink takes it
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready)
        begin
            limit_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    read_ok_next = s_tuser[1];
                    last_next    = s_tlast;
                    for (int i = 0; i < gbc_pkg::AXES; i++)
                    begin
                        accel_next[i] = s_tdata[i*AW +: AW];
                        gyro_next[i]  = s_tdata[(3+i)*GW +: GW];
                    end
                    acc_next  = '0;
                    axis_next = 2'd0;
                    if (!s_tuser[0])
                    begin
                        state_next = S_MEAS;
                    end
                    else if (s_tuser[1])
                    begin
                        state_next = S_SQ;
                    end
                    else
                    begin
                        state_next = S_UPD;
                    end
                end
            end

            S_MEAS:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = gbc_pkg::STATUS_MEAS;
                    m_tdata_next  = {{(128-OUT_USED){1'b0}}, rate[2], rate[1], rate[0],
                                     accel_reg[2], accel_reg[1], accel_reg[0]};
                    state_next    = S_IDLE;
                end
            end

            // Accumulate the squared magnitude, one axis per cycle
            S_SQ:
            begin
                acc_next  = alu_out.acc;
                axis_next = axis_reg + 2'd1;
                if (axis_reg == 2'd2)
                begin
                    state_next = S_UPD;
                end
            end

            // Compare with the squared limit and advance the run counters
            S_UPD:
            begin
                if (attempt_reg < MAX_CNT)
                begin
                    attempt_next = attempt_reg + 1'b1;
                end
                if (read_ok_reg)
                begin
                    if (alu_out.gt)
                    begin
                        motion_next = 1'b1;
                    end
                    if (good_reg < MAX_CNT)
                    begin
                        good_next = good_reg + 1'b1;
                        for (int i = 0; i < gbc_pkg::AXES; i++)
                        begin
                            sums_next[i] = sums_reg[i] + SW'(gyro_reg[i]);
                        end
                    end
                end
                state_next = last_reg ? S_DEC : S_IDLE;
            end

            // Judge the run
            S_DEC:
            begin
                if (run_few)
                begin
                    status_next = gbc_pkg::STATUS_FEW;
                    state_next  = S_DONE;
                end
                else if (motion_reg)
                begin
                    status_next = gbc_pkg::STATUS_MOTION;
                    state_next  = S_DONE;
                end
                else
                begin
                    status_next = gbc_pkg::STATUS_OK;
                    axis_next   = init_axis;
                    step_next   = '0;
                    rem_next    = '0;
                    dvd_next    = {init_mag, {gbc_pkg::BIAS_FRAC_BITS{1'b0}}};
                    neg_next    = init_sum[SW-1];
                    state_next  = S_DIV;
                end
            end

            // One quotient bit per cycle, then load the bias of the axis
            S_DIV:
            begin
                rem_next  = alu_out.rem;
                dvd_next  = alu_out.dvd;
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    bias_next[axis_reg] = quot_signed[BW-1:0];
                    if (axis_reg == 2'd2)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        axis_next = init_axis;
                        step_next = '0;
                        rem_next  = '0;
                        dvd_next  = {init_mag, {gbc_pkg::BIAS_FRAC_BITS{1'b0}}};
                        neg_next  = init_sum[SW-1];
                    end
                end
            end

            // Report the run status and clear the run
            S_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = status_reg;
                    m_tdata_next  = '0;
                    for (int i = 0; i < gbc_pkg::AXES; i++)
                    begin
                        sums_next[i] = '0;
                    end
                    attempt_next  = '0;
                    good_next     = '0;
                    motion_next   = 1'b0;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            limit_reg    <= gbc_pkg::LIMIT_W'(640);
            attempt_reg  <= '0;
            good_reg     <= '0;
            motion_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < gbc_pkg::AXES; i++)
            begin
                bias_reg[i] <= '0;
                sums_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            limit_reg    <= limit_next;
            attempt_reg  <= attempt_next;
            good_reg     <= good_next;
            motion_reg   <= motion_next;
            m_tvalid_reg <= m_tvalid_next;
            bias_reg     <= bias_next;
            sums_reg     <= sums_next;
        end
    end

    // Payload and work registers
    always_ff @(posedge clk)
    begin
        read_ok_reg <= read_ok_next;
        last_reg    <= last_next;
        accel_reg   <= accel_next;
        gyro_reg    <= gyro_next;
        axis_reg    <= axis_next;
        step_reg    <= step_next;
        acc_reg     <= acc_next;
        rem_reg     <= rem_next;
        dvd_reg     <= dvd_next;
        neg_reg     <= neg_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

endmodule

`default_nettype wire

[test/gyro_bias_calibrate_correct_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gyro bias calibration and correction unit testbench
// Streams six-axis IMU samples into the unit: measure samples, calibration
// runs with random content, broken runs and a counter saturation run, under
// several motion limits. Every sample accepted is applied to an in-bench
// calibration model; each result transfer is checked field by field against
// the oldest predicted result. Both stream sides idle at random, and the
// result side holds off once for a long stretch to fill the unit.
// ----------------------------------------------------------------------------

module gyro_bias_calibrate_correct_unit_tb;

    localparam int AXES           = gbc_pkg::AXES;
    localparam int ACCEL_W        = gbc_pkg::ACCEL_W;
    localparam int GYRO_W         = gbc_pkg::GYRO_W;
    localparam int LIMIT_W        = gbc_pkg::LIMIT_W;
    localparam int BIAS_W         = gbc_pkg::BIAS_W;
    localparam int STATUS_W       = gbc_pkg::STATUS_W;
    localparam int BIAS_FRAC_BITS = gbc_pkg::BIAS_FRAC_BITS;
    localparam int MAX_SAMPLES    = gbc_pkg::MAX_SAMPLES;

    localparam logic CMD_MEASURE   = 1'b0;
    localparam logic CMD_CALIBRATE = 1'b1;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 9;
    localparam int IDLE_PCT     = 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 150;
    localparam int PHASE_ITEMS  = 40;

    typedef struct packed {
        logic                        cmd;
        logic                        read_ok;
        logic                        last;
        logic [AXES-1:0][ACCEL_W-1:0] accel;
        logic [AXES-1:0][GYRO_W-1:0]  gyro;
    } imu_sample_t;

    typedef struct packed {
        logic [STATUS_W-1:0]          status;
        logic [AXES-1:0][ACCEL_W-1:0] accel;
        logic [AXES-1:0][BIAS_W-1:0]  rate;
    } imu_result_t;

    logic         clk        = 1'b0;
    logic         rst_n      = 1'b0;
    logic         cfg_valid  = 1'b0;
    logic         cfg_ready;
    logic [15:0]  cfg_data   = '0;
    logic         s_tvalid   = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata    = '0;
    logic [1:0]   s_tuser    = '0;
    logic         s_tlast    = 1'b0;
    logic         m_tvalid;
    logic         m_tready   = 1'b0;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;

    // Calibration model state
    logic [LIMIT_W-1:0] limit_model = 16'd640;
    longint             bias_model [AXES];
    longint             run_sums [AXES];
    int                 run_attempts;
    int                 run_good;
    bit                 run_motion;

    imu_sample_t samples_to_send [$];
    imu_result_t imu_results_due [$];
    imu_sample_t offered;
    imu_result_t due_result;

    int  queued_items   = 0;
    int  results_seen   = 0;
    int  mismatch_count = 0;
    int  ax;
    bit  steady_traffic = 1'b0;
    bit  hold_request   = 1'b0;
    bit  hold_done;
    int  backpressure_left;

    gyro_bias_calibrate_correct_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
        .s_tuser   (s_tuser),   // command, read_ok
        .s_tlast   (s_tlast),   // last_of_run
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // accel_x_out, accel_y_out, accel_z_out,
                                // rate_x_out, rate_y_out, rate_z_out, zero pad
        .m_tuser   (m_tuser)    // status
    );

    always #HALF_PERIOD clk = ~clk;

    // Apply one accepted sample to the model and queue the result it causes
    task automatic correct_or_calibrate(input imu_sample_t s);
        imu_result_t r;
        longint      g [AXES];
        longint      mag2;
        longint      lim2;
        int          i;
        for (i = 0; i < AXES; i++)
            g[i] = longint'($signed(s.gyro[i]));

        if (s.cmd == CMD_MEASURE)
        begin
            r.status = gbc_pkg::STATUS_MEAS;
            for (i = 0; i < AXES; i++)
            begin
                r.accel[i] = s.accel[i];
                r.rate[i]  = BIAS_W'(g[i] * (longint'(1) << BIAS_FRAC_BITS) - bias_model[i]);
            end
            imu_results_due.push_back(r);
            return;
        end

        if (run_attempts < MAX_SAMPLES)
            run_attempts++;

        if (s.read_ok)
        begin
            mag2 = g[0] * g[0] + g[1] * g[1] + g[2] * g[2];
            lim2 = longint'(limit_model) * longint'(limit_model);
            if (mag2 > lim2)
                run_motion = 1'b1;
            // Past saturation a good read is only checked for motion
            if (run_good < MAX_SAMPLES)
            begin
                run_good++;
                for (i = 0; i < AXES; i++)
                    run_sums[i] += g[i];
            end
        end

        if (!s.last)
            return;

        // Too few good reads outranks motion
        if (run_good == 0 || run_good < run_attempts / 2)
            r.status = gbc_pkg::STATUS_FEW;
        else if (run_motion)
            r.status = gbc_pkg::STATUS_MOTION;
        else
        begin
            r.status = gbc_pkg::STATUS_OK;
            for (i = 0; i < AXES; i++)
                bias_model[i] = (run_sums[i] * (longint'(1) << BIAS_FRAC_BITS))
                                / longint'(run_good);
        end
        r.accel = '0;
        r.rate  = '0;
        imu_results_due.push_back(r);

        for (i = 0; i < AXES; i++)
            run_sums[i] = 0;
        run_attempts = 0;
        run_good     = 0;
        run_motion   = 1'b0;
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("[%0t] result %0d: %s is %0d, expected %0d",
                 $time, results_seen, what, got, want);
    endtask

    // Sample stream driver: hold each sample until its transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            s_tlast  <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
                correct_or_calibrate(offered);
            if (samples_to_send.size() != 0 &&
                (steady_traffic || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                offered = samples_to_send.pop_front();
                s_tdata  <= {offered.gyro, offered.accel};
                s_tuser  <= {offered.read_ok, offered.cmd};
                s_tlast  <= offered.last;
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Long result hold-off, counted down once on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            backpressure_left <= 0;
            hold_done         <= 1'b0;
        end
        else if (hold_request && !hold_done)
        begin
            backpressure_left <= HOLD_CYCLES;
            hold_done         <= 1'b1;
        end
        else if (backpressure_left > 0)
            backpressure_left <= backpressure_left - 1;
    end

    // Result monitor: check each transfer against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (imu_results_due.size() == 0)
                    report_mismatch("unexpected result, status", m_tuser, -1);
                else
                begin
                    due_result = imu_results_due.pop_front();
                    if (m_tuser !== due_result.status)
                        report_mismatch("status", m_tuser, due_result.status);
                    for (ax = 0; ax < AXES; ax++)
                    begin
                        if (m_tdata[ACCEL_W*ax +: ACCEL_W] !== due_result.accel[ax])
                            report_mismatch($sformatf("accel[%0d]", ax),
                                            $signed(m_tdata[ACCEL_W*ax +: ACCEL_W]),
                                            $signed(due_result.accel[ax]));
                        if (m_tdata[3*ACCEL_W + BIAS_W*ax +: BIAS_W] !== due_result.rate[ax])
                            report_mismatch($sformatf("rate[%0d]", ax),
                                            $signed(m_tdata[3*ACCEL_W + BIAS_W*ax +: BIAS_W]),
                                            $signed(due_result.rate[ax]));
                    end
                end
            end
            m_tready <= (backpressure_left == 0) &&
                        (steady_traffic || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic queue_raw(input logic cmd, input logic ok, input logic last,
                             input int a0, input int a1, input int a2,
                             input int g0, input int g1, input int g2);
        imu_sample_t s;
        s.cmd      = cmd;
        s.read_ok  = ok;
        s.last     = last;
        s.accel[0] = a0[15:0];
        s.accel[1] = a1[15:0];
        s.accel[2] = a2[15:0];
        s.gyro[0]  = g0[15:0];
        s.gyro[1]  = g1[15:0];
        s.gyro[2]  = g2[15:0];
        samples_to_send.push_back(s);
        queued_items++;
    endtask

    // Measure sample; read_ok and last carry noise the unit must ignore
    task automatic queue_measure();
        queue_raw(CMD_MEASURE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 65535));
    endtask

    task automatic queue_cal(input logic ok, input logic last,
                             input int g0, input int g1, input int g2);
        queue_raw(CMD_CALIBRATE, ok, last, $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 65535), g0, g1, g2);
    endtask

    // Calibration run: mode 0 still sensor, 1 full range, 2 near the limit
    task automatic queue_run(input int len, input int good_pct, input int mode);
        int k;
        int a;
        int gv [AXES];
        bit ok;
        for (k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_measure();
            ok = ($urandom_range(0, 99) < good_pct);
            for (a = 0; a < AXES; a++)
            begin
                case (mode)
                    0:       gv[a] = $urandom_range(0, 300) - 150;
                    1:       gv[a] = $urandom_range(0, 65535) - 32768;
                    default: gv[a] = 0;
                endcase
            end
            if (mode == 2)
            begin
                a = $urandom_range(0, AXES - 1);
                gv[a] = int'(limit_model) + int'($urandom_range(0, 2)) - 1;
                if (gv[a] > 32767)
                    gv[a] = 32767;
                if ($urandom_range(0, 1))
                    gv[a] = -gv[a];
            end
            queue_cal(ok, k == len - 1, gv[0], gv[1], gv[2]);
        end
    endtask

    task automatic random_traffic(input int count);
        int start;
        int pick;
        start = queued_items;
        while (queued_items - start < count)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
                repeat ($urandom_range(1, 4)) queue_measure();
            else if (pick < 8)
            begin
                pick = $urandom_range(0, 99);
                queue_run($urandom_range(1, 12), 85, (pick < 70) ? 0 : (pick < 85) ? 2 : 1);
            end
            else if (pick == 8)
                queue_run($urandom_range(1, 12), 35, 0);
            else
                queue_run($urandom_range(1, 12), $urandom_range(0, 100), 1);
        end
    endtask

    // Wait until every sample is sent and every result is back, then settle
    task automatic drain_samples();
        while (samples_to_send.size() != 0 || s_tvalid || imu_results_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_motion_limit(input logic [LIMIT_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        limit_model = value;
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        #8_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int k;
        for (k = 0; k < AXES; k++)
        begin
            bias_model[k] = 0;
            run_sums[k]   = 0;
        end
        run_attempts = 0;
        run_good     = 0;
        run_motion   = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed samples under the reset limit of 640
        queue_raw(CMD_MEASURE, 1'b1, 1'b1, -32768, 32767, 0, -32768, 32767, 0);
        queue_raw(CMD_MEASURE, 1'b0, 1'b0, 32767, -32768, -1, 32767, -32768, -1);
        queue_cal(1'b0, 1'b1, 5, 5, 5);             // single bad read: no good reads
        queue_cal(1'b1, 1'b1, 640, 0, 0);           // magnitude equal to limit passes
        queue_raw(CMD_MEASURE, 1'b0, 1'b0, 0, 0, 0, -32768, 0, 0);
        queue_cal(1'b1, 1'b1, 641, 0, 0);           // just over the limit
        queue_cal(1'b1, 1'b0, 0, 0, -700);          // motion and too few reads
        queue_cal(1'b0, 1'b0, 0, 0, 0);
        queue_cal(1'b0, 1'b0, 0, 0, 0);
        queue_cal(1'b0, 1'b1, 0, 0, 0);
        queue_cal(1'b1, 1'b0, -1, 1, 2);            // sums that truncate toward zero
        queue_raw(CMD_MEASURE, 1'b1, 1'b1, 100, -100, 2048, 16, -16, 0);
        queue_cal(1'b1, 1'b0, 0, 0, 0);
        queue_cal(1'b1, 1'b1, 0, 0, 0);
        queue_raw(CMD_MEASURE, 1'b0, 1'b0, 0, 0, 0, 0, 0, 0);
        queue_cal(1'b0, 1'b0, 0, 0, 0);
        queue_cal(1'b1, 1'b1, 5, -5, 5);            // one of two reads is enough
        queue_cal(1'b0, 1'b0, 1, 1, 1);
        queue_cal(1'b0, 1'b0, 1, 1, 1);
        queue_cal(1'b0, 1'b0, 1, 1, 1);
        queue_cal(1'b1, 1'b1, -3, 0, 0);            // one of four reads is not
        queue_cal(1'b0, 1'b0, 32767, 32767, 32767); // bad reads skip the motion check
        queue_cal(1'b0, 1'b0, -32768, -32768, -32768);
        queue_cal(1'b1, 1'b1, 7, 7, 7);
        drain_samples();

        // Zero limit: any moving good read is rejected
        write_motion_limit(16'd0);
        random_traffic(PHASE_ITEMS);
        drain_samples();

        // Widest limit: full-scale runs load large biases
        write_motion_limit(16'hFFFF);
        queue_cal(1'b1, 1'b0, -32768, -32768, -32768);
        queue_cal(1'b1, 1'b1, -32768, -32768, -32768);
        queue_raw(CMD_MEASURE, 1'b0, 1'b1, 0, 0, 0, 32767, 32767, 32767);
        random_traffic(PHASE_ITEMS);
        drain_samples();

        // Random limits; fill the unit once, run one phase without gaps
        for (k = 0; k < 3; k++)
        begin
            write_motion_limit((k == 2) ? 16'($urandom_range(1, 2000))
                                        : 16'($urandom_range(1, 65534)));
            if (k == 0)
            begin
                hold_request = 1'b1;
                repeat (PHASE_ITEMS) queue_measure();
            end
            steady_traffic = (k == 1);
            random_traffic(PHASE_ITEMS);
            drain_samples();
            steady_traffic = 1'b0;
        end

        // Saturated counters: late reads must not reach the sums
        write_motion_limit(16'd640);
        for (k = 0; k < MAX_SAMPLES + 6; k++)
        begin
            if (k < MAX_SAMPLES)
                queue_cal(1'b1, 1'b0, $urandom_range(0, 200) - 100,
                          $urandom_range(0, 200) - 100, $urandom_range(0, 200) - 100);
            else
                queue_cal(1'b1, k == MAX_SAMPLES + 5, 150, 150, 150);
        end
        repeat (4) queue_measure();
        drain_samples();

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
